/* hdl/brss_pkg.sv */
// shared types and constants for the blit rotate/scale setup block
package brss_pkg;

  // fixed widths of the result fields
  localparam int unsigned COORD_OUT_W = 13;
  localparam int unsigned STEP_OUT_W  = 24;
  localparam int unsigned ASEL_W      = 2;
  localparam int unsigned ROP_W       = 13;

  // result tdata: fields packed from bit 0, padded to whole bytes
  localparam int unsigned OUT_FIELDS_W = 4 * COORD_OUT_W + 1 + 2 * STEP_OUT_W + ASEL_W + ROP_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_ROTATION  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLEND     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RASTER_OP = 2'd2;

  localparam logic [7:0] RASTER_OP_RESET = 8'd204;

  // rotation / flip codes; other codes mean no rotation
  localparam logic [2:0] ROT_90     = 3'd1;
  localparam logic [2:0] ROT_180    = 3'd2;
  localparam logic [2:0] ROT_270    = 3'd3;
  localparam logic [2:0] ROT_FLIP_X = 3'd4;
  localparam logic [2:0] ROT_FLIP_Y = 3'd5;

  // alpha source codes
  localparam logic [ASEL_W-1:0] ASEL_BLEND_FIELD = 2'd0;
  localparam logic [ASEL_W-1:0] ASEL_SRC_ALPHA   = 2'd1;
  localparam logic [ASEL_W-1:0] ASEL_REG_ALPHA   = 2'd2;

  localparam int unsigned BLEND_SHIFT = 10;

  // fields that ride along the divider chain untouched
  typedef struct packed {
    logic [COORD_OUT_W-1:0] origin_x;
    logic [COORD_OUT_W-1:0] origin_y;
    logic [COORD_OUT_W-1:0] far_x;
    logic [COORD_OUT_W-1:0] far_y;
    logic                   stretch;
    logic [ASEL_W-1:0]      alpha_select;
    logic [ROP_W-1:0]       rop_word;
    logic                   bad_rect;
  } side_t;

endpackage

/* hdl/brss_setup.sv */
// entry stage: rectangle checks, rotation, virtual size, alpha and rop decode
module brss_setup import brss_pkg::*; #(
  parameter int unsigned COORD_BITS       = 12,
  parameter int unsigned FRAC_BITS        = 11,
  parameter int unsigned PIXEL_ALPHA_CODE = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [COORD_BITS-1:0]                src_left_i,
  input  logic [COORD_BITS-1:0]                src_top_i,
  input  logic [COORD_BITS-1:0]                src_right_i,
  input  logic [COORD_BITS-1:0]                src_bottom_i,
  input  logic [COORD_BITS-1:0]                dst_left_i,
  input  logic [COORD_BITS-1:0]                dst_top_i,
  input  logic [COORD_BITS-1:0]                dst_right_i,
  input  logic [COORD_BITS-1:0]                dst_bottom_i,
  input  logic                                 src_has_alpha_i,
  input  logic [2:0]                           rotation_mode_i,
  input  logic [2:0]                           blend_mode_i,
  input  logic [7:0]                           raster_op_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [COORD_BITS+FRAC_BITS:0]        x_dividend_o,
  output logic [COORD_BITS:0]                  x_divisor_o,
  output logic [COORD_BITS+FRAC_BITS:0]        y_dividend_o,
  output logic [COORD_BITS:0]                  y_divisor_o,
  output side_t                                side_o
);

  localparam int unsigned SW = COORD_BITS + 1;
  localparam int unsigned QW = COORD_BITS + 1 + FRAC_BITS;

  logic [SW-1:0] sw, sh, dw, dh, vw, vh;
  logic [SW-1:0] ox, oy, fx, fy;
  logic          bad;
  side_t         side_d, side_q;
  logic [QW-1:0] xdd_d, ydd_d, xdd_q, ydd_q;
  logic [SW-1:0] xdv_d, ydv_d, xdv_q, ydv_q;
  logic          valid_q, advance;

  assign bad = (src_right_i < src_left_i) || (src_bottom_i < src_top_i) ||
               (dst_right_i < dst_left_i) || (dst_bottom_i < dst_top_i);

  assign sw = SW'(src_right_i) - SW'(src_left_i) + SW'(1);
  assign sh = SW'(src_bottom_i) - SW'(src_top_i) + SW'(1);
  assign dw = SW'(dst_right_i) - SW'(dst_left_i) + SW'(1);
  assign dh = SW'(dst_bottom_i) - SW'(dst_top_i) + SW'(1);

  always_comb begin
    unique case (rotation_mode_i)
      ROT_90: begin
        ox = SW'(dst_right_i);  oy = SW'(dst_top_i);
        fx = SW'(dst_right_i) + dh - SW'(1);
        fy = SW'(dst_top_i) + dw - SW'(1);
        vw = sh; vh = sw;
      end
      ROT_180: begin
        ox = SW'(dst_right_i);  oy = SW'(dst_bottom_i);
        fx = SW'(dst_right_i) + dw - SW'(1);
        fy = SW'(dst_bottom_i) + dh - SW'(1);
        vw = sw; vh = sh;
      end
      ROT_270: begin
        ox = SW'(dst_left_i);   oy = SW'(dst_bottom_i);
        fx = SW'(dst_left_i) + dh - SW'(1);
        fy = SW'(dst_bottom_i) + dw - SW'(1);
        vw = sh; vh = sw;
      end
      ROT_FLIP_X: begin
        ox = SW'(dst_left_i);   oy = SW'(dst_bottom_i);
        fx = SW'(dst_left_i) + dw - SW'(1);
        fy = SW'(dst_bottom_i) + dh - SW'(1);
        vw = sw; vh = sh;
      end
      ROT_FLIP_Y: begin
        ox = SW'(dst_right_i);  oy = SW'(dst_top_i);
        fx = SW'(dst_right_i) + dw - SW'(1);
        fy = SW'(dst_top_i) + dh - SW'(1);
        vw = sw; vh = sh;
      end
      default: begin
        ox = SW'(dst_left_i);   oy = SW'(dst_top_i);
        fx = SW'(dst_right_i);  fy = SW'(dst_bottom_i);
        vw = sw; vh = sh;
      end
    endcase
  end

  always_comb begin
    side_d = '0;
    xdd_d  = '0;
    ydd_d  = '0;
    xdv_d  = SW'(1);
    ydv_d  = SW'(1);
    if (bad) begin
      side_d.bad_rect = 1'b1;
    end else begin
      side_d.origin_x = COORD_OUT_W'(ox);
      side_d.origin_y = COORD_OUT_W'(oy);
      side_d.far_x    = COORD_OUT_W'(fx);
      side_d.far_y    = COORD_OUT_W'(fy);
      side_d.stretch  = (vw != dw) || (vh != dh);
      if (blend_mode_i == 3'(PIXEL_ALPHA_CODE)) begin
        side_d.alpha_select = src_has_alpha_i ? ASEL_SRC_ALPHA : ASEL_REG_ALPHA;
        side_d.rop_word     = ROP_W'(raster_op_i);
      end else begin
        side_d.alpha_select = ASEL_BLEND_FIELD;
        side_d.rop_word     = (ROP_W'(blend_mode_i) << BLEND_SHIFT) | ROP_W'(raster_op_i);
      end
      // a zero dividend gives a zero step when not stretching
      if (side_d.stretch) begin
        xdd_d = {vw, FRAC_BITS'(0)};
        ydd_d = {vh, FRAC_BITS'(0)};
      end
      xdv_d = dw;
      ydv_d = dh;
    end
  end

  assign advance    = !valid_q || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      side_q <= side_d;
      xdd_q  <= xdd_d;
      ydd_q  <= ydd_d;
      xdv_q  <= xdv_d;
      ydv_q  <= ydv_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign side_o       = side_q;
  assign x_dividend_o = xdd_q;
  assign y_dividend_o = ydd_q;
  assign x_divisor_o  = xdv_q;
  assign y_divisor_o  = ydv_q;

endmodule

/* hdl/brss_div_cell.sv */
// one restoring-division cell: one quotient bit for the x and y steps
module brss_div_cell import brss_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS:0]           x_rem_i,
  input  logic [COORD_BITS+FRAC_BITS:0] x_work_i,
  input  logic [COORD_BITS:0]           x_div_i,
  input  logic [COORD_BITS:0]           y_rem_i,
  input  logic [COORD_BITS+FRAC_BITS:0] y_work_i,
  input  logic [COORD_BITS:0]           y_div_i,
  input  side_t                         side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_BITS:0]           x_rem_o,
  output logic [COORD_BITS+FRAC_BITS:0] x_work_o,
  output logic [COORD_BITS:0]           x_div_o,
  output logic [COORD_BITS:0]           y_rem_o,
  output logic [COORD_BITS+FRAC_BITS:0] y_work_o,
  output logic [COORD_BITS:0]           y_div_o,
  output side_t                         side_o
);

  localparam int unsigned SW = COORD_BITS + 1;
  localparam int unsigned QW = COORD_BITS + 1 + FRAC_BITS;

  logic [SW:0]   x_trial, y_trial;
  logic          x_ge, y_ge;
  logic [SW-1:0] x_rem_d, y_rem_d, x_rem_q, y_rem_q, x_div_q, y_div_q;
  logic [QW-1:0] x_work_d, y_work_d, x_work_q, y_work_q;
  side_t         side_q;
  logic          valid_q, advance;

  // bring down the next dividend bit, subtract when it fits
  assign x_trial  = {x_rem_i, x_work_i[QW-1]};
  assign y_trial  = {y_rem_i, y_work_i[QW-1]};
  assign x_ge     = x_trial >= {1'b0, x_div_i};
  assign y_ge     = y_trial >= {1'b0, y_div_i};
  assign x_rem_d  = x_ge ? SW'(x_trial - {1'b0, x_div_i}) : SW'(x_trial);
  assign y_rem_d  = y_ge ? SW'(y_trial - {1'b0, y_div_i}) : SW'(y_trial);
  assign x_work_d = {x_work_i[QW-2:0], x_ge};
  assign y_work_d = {y_work_i[QW-2:0], y_ge};

  assign advance    = !valid_q || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      x_rem_q  <= x_rem_d;
      y_rem_q  <= y_rem_d;
      x_work_q <= x_work_d;
      y_work_q <= y_work_d;
      x_div_q  <= x_div_i;
      y_div_q  <= y_div_i;
      side_q   <= side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign x_rem_o     = x_rem_q;
  assign y_rem_o     = y_rem_q;
  assign x_work_o    = x_work_q;
  assign y_work_o    = y_work_q;
  assign x_div_o     = x_div_q;
  assign y_div_o     = y_div_q;
  assign side_o      = side_q;

endmodule

/* hdl/blit_rotate_scale_setup_core.sv */
// top level of the blit rotate/scale setup block
//
// channels: s_axis carries one blit command per transfer (eight rectangle
// edges in tdata, the source alpha flag in tuser); m_axis returns one setup
// result per command (origin, far corner, stretch, steps, alpha select, rop
// word in tdata, the bad rectangle flag in tuser). cfg writes rotation mode,
// blend mode and raster op by index; it is always ready
// pipeline: one entry stage plus one division cell per quotient bit,
// registered in turn from the s_axis transfer to m_axis tvalid
// throughput: one command per cycle while m_axis tready is high; every
// cell of the divider chain holds its own command, so the chain takes a
// new command each cycle unless the output stalls
// reset: all stages empty, rotation and blend mode 0, raster op 204
// stall: when m_axis tready is low the chain keeps filling its empty cells
// and s_axis tready falls only once every cell holds a command
module blit_rotate_scale_setup_core import brss_pkg::*; #(
  parameter int unsigned COORD_BITS       = 12,
  parameter int unsigned FRAC_BITS        = 11,
  parameter int unsigned PIXEL_ALPHA_CODE = 3
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // src_left, src_top, src_right, src_bottom, dst_left, dst_top, dst_right, dst_bottom
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // src_has_alpha
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // origin_x, origin_y, far_x, far_y, stretch, x_step, y_step, alpha_select, rop_word
  output logic [OUT_DATA_W-1:0]                     m_axis_tdata,
  // bad_rect
  output logic                                      m_axis_tuser,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]                     cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]                     cfg_data_i
);

  localparam int unsigned SW = COORD_BITS + 1;
  localparam int unsigned QW = COORD_BITS + 1 + FRAC_BITS;

  // configuration registers
  logic [2:0] rotation_q, blend_q;
  logic [7:0] raster_op_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q  <= '0;
      blend_q     <= '0;
      raster_op_q <= RASTER_OP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_ROTATION:  rotation_q  <= cfg_data_i[2:0];
        REG_BLEND:     blend_q     <= cfg_data_i[2:0];
        REG_RASTER_OP: raster_op_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chain links: index k feeds cell k, index QW is the chain output
  logic          valid_w [QW+1];
  logic          ready_w [QW+1];
  logic [SW-1:0] x_rem_w [QW+1];
  logic [SW-1:0] y_rem_w [QW+1];
  logic [QW-1:0] x_work_w [QW+1];
  logic [QW-1:0] y_work_w [QW+1];
  logic [SW-1:0] x_div_w [QW+1];
  logic [SW-1:0] y_div_w [QW+1];
  side_t         side_w [QW+1];

  brss_setup #(
    .COORD_BITS       (COORD_BITS),
    .FRAC_BITS        (FRAC_BITS),
    .PIXEL_ALPHA_CODE (PIXEL_ALPHA_CODE)
  ) u_setup (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .src_left_i      (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
    .src_top_i       (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
    .src_right_i     (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
    .src_bottom_i    (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
    .dst_left_i      (s_axis_tdata[4*COORD_BITS +: COORD_BITS]),
    .dst_top_i       (s_axis_tdata[5*COORD_BITS +: COORD_BITS]),
    .dst_right_i     (s_axis_tdata[6*COORD_BITS +: COORD_BITS]),
    .dst_bottom_i    (s_axis_tdata[7*COORD_BITS +: COORD_BITS]),
    .src_has_alpha_i (s_axis_tuser),
    .rotation_mode_i (rotation_q),
    .blend_mode_i    (blend_q),
    .raster_op_i     (raster_op_q),
    .out_valid_o     (valid_w[0]),
    .out_ready_i     (ready_w[0]),
    .x_dividend_o    (x_work_w[0]),
    .x_divisor_o     (x_div_w[0]),
    .y_dividend_o    (y_work_w[0]),
    .y_divisor_o     (y_div_w[0]),
    .side_o          (side_w[0])
  );

  // partial remainders start at zero
  assign x_rem_w[0] = '0;
  assign y_rem_w[0] = '0;

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_cell
    brss_div_cell #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .x_rem_i     (x_rem_w[k]),
      .x_work_i    (x_work_w[k]),
      .x_div_i     (x_div_w[k]),
      .y_rem_i     (y_rem_w[k]),
      .y_work_i    (y_work_w[k]),
      .y_div_i     (y_div_w[k]),
      .side_i      (side_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .x_rem_o     (x_rem_w[k+1]),
      .x_work_o    (x_work_w[k+1]),
      .x_div_o     (x_div_w[k+1]),
      .y_rem_o     (y_rem_w[k+1]),
      .y_work_o    (y_work_w[k+1]),
      .y_div_o     (y_div_w[k+1]),
      .side_o      (side_w[k+1])
    );
  end

  // last cell is the output register; its work words hold the quotients
  side_t                  res;
  logic [STEP_OUT_W-1:0]  x_step, y_step;
  logic [OUT_FIELDS_W-1:0] fields;

  assign res            = side_w[QW];
  assign x_step         = STEP_OUT_W'(x_work_w[QW]);
  assign y_step         = STEP_OUT_W'(y_work_w[QW]);
  assign ready_w[QW]    = m_axis_tready;
  assign m_axis_tvalid  = valid_w[QW];
  assign fields = {res.rop_word, res.alpha_select, y_step, x_step, res.stretch,
                   res.far_y, res.far_x, res.origin_y, res.origin_x};
  assign m_axis_tdata   = OUT_DATA_W'(fields);
  assign m_axis_tuser   = res.bad_rect;

endmodule
